// ===== sv/ogi_pkg.sv =====
// Occupancy grid inflation: shared types, register codes and reset values.
// Used by every module of the block; depends on nothing.
package ogi_pkg;

  typedef struct packed {
    logic              func;
    logic signed [7:0] cell_value;
  } in_word_t;

  typedef struct packed {
    logic signed [7:0] out_value;
    logic              frame_last;
  } out_word_t;

  // One grid cell as kept in the line cells: obstacle flag and raw value.
  typedef struct packed {
    logic       occ;
    logic [7:0] value;
  } cell_t;

  localparam int DistW = 4;

  // One window column: nearest obstacle row distance and the center-row value.
  typedef struct packed {
    logic             hit;
    logic [DistW-1:0] row_dist;
    logic [7:0]       value;
  } col_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;
  localparam int FifoCntW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RADIUS   = 3'd0,
    REG_WIDTH    = 3'd1,
    REG_HEIGHT   = 3'd2,
    REG_OCCUPIED = 3'd3,
    REG_INFLATED = 3'd4
  } reg_idx_e;

  localparam int                RadiusReset   = 4;
  localparam int                WidthReset    = 340;
  localparam int                HeightReset   = 131;
  localparam logic signed [7:0] OccupiedReset = 8'sd100;
  localparam logic signed [7:0] InflatedReset = 8'sd80;

  function automatic logic [9:0] sq(logic [4:0] a);
    sq = 10'(a) * 10'(a);
  endfunction

  // Column reaches the center when dist^2 + dx^2 < (radius+1)^2.
  function automatic logic reach(col_t c, logic [4:0] dx_abs, logic [4:0] lim_root);
    reach = c.hit && ((sq({1'b0, c.row_dist}) + sq(dx_abs)) < sq(lim_root));
  endfunction

endpackage

// ===== sv/occupancy_grid_inflation.sv =====
// Occupancy grid inflation, top level: config registers, stream control, line
// cells, column chain and result queue. Uses ogi_pkg and all ogi_* modules.
//
// Takes one grid cell per clock in raster order while in_stall_o is low and
// returns one inflated cell per clock unless the receiver stalls; the result
// for a cell is decided by the word taken radius*frame_width+radius words
// after it and goes through the pending register into the result queue before
// it is offered, so after the last pixel as many drain words pull out the rest.
// When that lag is not shorter than the frame, the input stalls right after the last
// pixel while the window fills with empty cells. The window is a chain of
// 2*MAX_RADIUS line cells, each one memory of MAX_WIDTH-1 words read and
// written once per cell, feeding a chain of column cells; a four-word queue at
// the output keeps the input moving while a finished result waits. A write of
// any register restarts the frame.
module occupancy_grid_inflation #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 7
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ogi_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ogi_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ogi_pkg::in_word_t                in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output ogi_pkg::out_word_t               out_word_o
);
  import ogi_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int NRow  = 2 * MAX_RADIUS;
  localparam int NTap  = 2 * MAX_RADIUS + 1;
  localparam int SRW   = $clog2(2 * MAX_RADIUS + 2);
  localparam int LW    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
  localparam int Depth = (MAX_WIDTH > 1) ? MAX_WIDTH - 1 : 1;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int RMax  = (MAX_RADIUS > 7) ? 7 : MAX_RADIUS;
  localparam logic [2:0]    RadRst = 3'((RadiusReset > RMax) ? RMax : RadiusReset);
  localparam logic [XW-1:0] WidRst = XW'((WidthReset > MAX_WIDTH) ? MAX_WIDTH : WidthReset);
  localparam logic [HW-1:0] HgtRst =
    HW'((HeightReset > MAX_HEIGHT) ? MAX_HEIGHT : HeightReset);
  localparam logic [SRW-1:0] SMax = SRW'(2 * MAX_RADIUS);

  // configuration
  logic [2:0]        radius_q;
  logic [XW-1:0]     width_q;
  logic [HW-1:0]     height_q;
  logic signed [7:0] occ_q, inf_q;
  logic              cfg_hit;

  // stream control
  logic [XW-1:0]  icol_q, ocol_q, scol_q;
  logic [HW-1:0]  irow_q, orow_q;
  logic [SRW-1:0] srow_q, vrow_q;
  logic [LW-1:0]  gap_q, lag;
  logic [PtrW-1:0] ptr_q;
  logic           draining_q;
  logic           room, gap_short, take, pix, tick, catchup, step, emit;
  logic           in_last, out_last, restart;

  // result handoff
  logic          pend_q, pend_last_q;
  logic [XW-1:0] pend_col_q;
  logic [FifoCntW-1:0] fifo_cnt;
  out_word_t     res_word;

  // window
  cell_t new_q;
  cell_t new_cell;
  cell_t rows [NTap];
  col_t  taps [NTap];
  col_t  col_new;
  logic [NTap-1:0]       mask;
  logic [MAX_RADIUS:0]   flag;
  logic [NTap-1:0]       col_reach;
  logic [4:0]            lim_root;
  logic [DistW-1:0]      dmin;
  logic [7:0]            row_val, ctr_val;
  logic                  hit_any;

  always_comb begin
    unique case (cfg_idx_i)
      REG_RADIUS, REG_WIDTH, REG_HEIGHT, REG_OCCUPIED, REG_INFLATED: cfg_hit = cfg_we_i;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadRst;
      width_q  <= WidRst;
      height_q <= HgtRst;
      occ_q    <= OccupiedReset;
      inf_q    <= InflatedReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIUS: begin
          radius_q <= (32'(cfg_data_i[2:0]) > RMax) ? 3'(RMax) : cfg_data_i[2:0];
        end
        REG_WIDTH: begin
          if (cfg_data_i == '0) width_q <= XW'(1);
          else if (32'(cfg_data_i) > MAX_WIDTH) width_q <= XW'(MAX_WIDTH);
          else width_q <= XW'(cfg_data_i);
        end
        REG_HEIGHT: begin
          if (cfg_data_i[8:0] == '0) height_q <= HW'(1);
          else if (32'(cfg_data_i[8:0]) > MAX_HEIGHT) height_q <= HW'(MAX_HEIGHT);
          else height_q <= HW'(cfg_data_i[8:0]);
        end
        REG_OCCUPIED: occ_q <= cfg_data_i[7:0];
        REG_INFLATED: inf_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign lag = LW'(radius_q) * LW'(width_q) + LW'(radius_q);

  always_comb begin
    room       = (FifoCntW'(pend_q) + fifo_cnt) <= FifoCntW'(2);
    gap_short  = gap_q < lag;
    in_stall_o = !room || (draining_q && gap_short);
    take       = in_valid_i && !in_stall_o;
    pix        = take && !in_word_i.func && !draining_q;
    tick       = take && draining_q;
    catchup    = draining_q && gap_short && room;
    step       = pix || tick || catchup;
    emit       = (pix || tick) && !gap_short;
    in_last    = (icol_q == width_q - XW'(1)) && (irow_q == height_q - HW'(1));
    out_last   = (ocol_q == width_q - XW'(1)) && (orow_q == height_q - HW'(1));
    restart    = cfg_hit || (emit && out_last);
    new_cell.occ   = pix && (in_word_i.cell_value == occ_q);
    new_cell.value = in_word_i.cell_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icol_q      <= '0;
      irow_q      <= '0;
      ocol_q      <= '0;
      orow_q      <= '0;
      scol_q      <= '0;
      srow_q      <= '0;
      vrow_q      <= '0;
      gap_q       <= '0;
      ptr_q       <= '0;
      draining_q  <= 1'b0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      pend_col_q  <= '0;
    end else begin
      pend_q <= emit;
      if (emit) begin
        pend_last_q <= out_last;
        pend_col_q  <= ocol_q;
      end
      if (pix) begin
        if (icol_q == width_q - XW'(1)) begin
          if (irow_q == height_q - HW'(1)) draining_q <= 1'b1;
          else begin
            icol_q <= '0;
            irow_q <= irow_q + HW'(1);
          end
        end else begin
          icol_q <= icol_q + XW'(1);
        end
      end
      if (emit) begin
        if (ocol_q == width_q - XW'(1)) begin
          ocol_q <= '0;
          orow_q <= orow_q + HW'(1);
        end else begin
          ocol_q <= ocol_q + XW'(1);
        end
      end
      if (step) begin
        vrow_q <= srow_q;
        if ((XW+1)'(ptr_q) + (XW+1)'(2) >= (XW+1)'(width_q)) ptr_q <= '0;
        else ptr_q <= ptr_q + PtrW'(1);
        if (scol_q == width_q - XW'(1)) begin
          scol_q <= '0;
          if (srow_q != SMax) srow_q <= srow_q + SRW'(1);
        end else begin
          scol_q <= scol_q + XW'(1);
        end
        if (!emit) gap_q <= gap_q + LW'(1);
      end
      // a register write or the final result starts a new frame
      if (restart) begin
        icol_q     <= '0;
        irow_q     <= '0;
        ocol_q     <= '0;
        orow_q     <= '0;
        scol_q     <= '0;
        srow_q     <= '0;
        gap_q      <= '0;
        draining_q <= 1'b0;
        if (cfg_hit) ptr_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      new_q <= new_cell;
    end
  end

  assign rows[0] = new_q;

  for (genvar k = 1; k <= NRow; k++) begin : g_row
    ogi_row_cell #(
      .Depth(Depth),
      .PtrW (PtrW)
    ) u_row (
      .clk_i   (clk_i),
      .step_i  (step),
      .bypass_i(width_q == XW'(1)),
      .ptr_i   (ptr_q),
      .cell_i  (rows[k-1]),
      .cell_o  (rows[k])
    );
  end

  // summarize the newest column: nearest obstacle row around the center row
  always_comb begin
    flag    = '0;
    row_val = rows[0].value;
    for (int k = 0; k < NTap; k++) begin
      mask[k] = rows[k].occ && (5'(k) <= {1'b0, radius_q, 1'b0}) && (SRW'(k) <= vrow_q);
      if (3'(k) == radius_q && k <= 7) row_val = rows[k].value;
    end
    for (int k = 0; k < NTap; k++) begin
      for (int j = 0; j <= MAX_RADIUS; j++) begin
        if (mask[k] && ((5'(k) >= 5'(radius_q)) ? (5'(k) - 5'(radius_q)) :
                        (5'(radius_q) - 5'(k))) == 5'(j)) begin
          flag[j] = 1'b1;
        end
      end
    end
    dmin = '0;
    for (int j = MAX_RADIUS; j >= 0; j--) begin
      if (flag[j]) dmin = DistW'(j);
    end
    col_new.hit      = |flag;
    col_new.row_dist = dmin;
    col_new.value    = row_val;
  end

  assign taps[0] = col_new;

  for (genvar i = 0; i < NRow; i++) begin : g_col
    ogi_col_cell #(
      .Idx(i),
      .XW (XW)
    ) u_col (
      .clk_i   (clk_i),
      .step_i  (step),
      .radius_i(radius_q),
      .width_i (width_q),
      .pcol_i  (pend_col_q),
      .col_i   (taps[i]),
      .col_o   (taps[i+1]),
      .reach_o (col_reach[i+1])
    );
  end

  assign lim_root = 5'(radius_q) + 5'd1;

  always_comb begin
    col_reach[0] = ((XW+1)'(pend_col_q) + (XW+1)'(radius_q) < (XW+1)'(width_q)) &&
                   reach(taps[0], 5'(radius_q), lim_root);
    hit_any = |col_reach;
    ctr_val = taps[0].value;
    for (int i = 0; i < NTap; i++) begin
      if (5'(i) == 5'(radius_q)) ctr_val = taps[i].value;
    end
    res_word.out_value  = (hit_any && (inf_q > $signed(ctr_val))) ? inf_q : $signed(ctr_val);
    res_word.frame_last = pend_last_q;
  end

  ogi_out_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (pend_q),
    .word_i (res_word),
    .stall_i(out_stall_i),
    .valid_o(out_valid_o),
    .word_o (out_word_o),
    .count_o(fifo_cnt)
  );

  a_fifo_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> fifo_cnt <= FifoCntW'(3))
    else $error("result queue overrun");

  a_gap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gap_q <= lag)
    else $error("stream ran ahead of the window lag");

  a_drain_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draining_q |-> in_last)
    else $error("draining before the last pixel");

endmodule

// ===== sv/ogi_row_cell.sv =====
// Occupancy grid inflation: one line cell, delays the cell stream by one row.
// Ring memory of frame_width-1 words plus a registered read; uses ogi_pkg.
module ogi_row_cell #(
  parameter int Depth = 511,
  parameter int PtrW  = 9
) (
  input  logic            clk_i,
  input  logic            step_i,
  input  logic            bypass_i,
  input  logic [PtrW-1:0] ptr_i,
  input  ogi_pkg::cell_t  cell_i,
  output ogi_pkg::cell_t  cell_o
);
  import ogi_pkg::*;

  cell_t mem [Depth];
  cell_t rd_q;
  cell_t byp_q;

  // read the old word before it is overwritten
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      rd_q       <= mem[ptr_i];
      mem[ptr_i] <= cell_i;
      byp_q      <= cell_i;
    end
  end

  // a one-column frame has a row delay of a single word
  assign cell_o = bypass_i ? byp_q : rd_q;

endmodule

// ===== sv/ogi_col_cell.sv =====
// Occupancy grid inflation: one window column cell of the horizontal chain.
// Holds a column summary and tests it against the current center; uses ogi_pkg.
module ogi_col_cell #(
  parameter int Idx = 0,
  parameter int XW  = 10
) (
  input  logic          clk_i,
  input  logic          step_i,
  input  logic [2:0]    radius_i,
  input  logic [XW-1:0] width_i,
  input  logic [XW-1:0] pcol_i,
  input  ogi_pkg::col_t col_i,
  output ogi_pkg::col_t col_o,
  output logic          reach_o
);
  import ogi_pkg::*;

  localparam logic [4:0] Pos = 5'(Idx + 1);

  col_t          col_q;
  logic [XW+1:0] base;
  logic [XW+1:0] xpos;
  logic [4:0]    dx_abs;
  logic          in_x;

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      col_q <= col_i;
    end
  end

  always_comb begin
    base   = (XW+2)'(pcol_i) + (XW+2)'(radius_i);
    xpos   = base - (XW+2)'(Pos);
    dx_abs = (5'(radius_i) >= Pos) ? (5'(radius_i) - Pos) : (Pos - 5'(radius_i));
    in_x   = (Pos <= {1'b0, radius_i, 1'b0}) && (base >= (XW+2)'(Pos)) &&
             (xpos < (XW+2)'(width_i));
    reach_o = in_x && reach(col_q, dx_abs, 5'(radius_i) + 5'd1);
  end

  assign col_o = col_q;

endmodule

// ===== sv/ogi_out_fifo.sv =====
// Occupancy grid inflation: four-word result queue in front of the output port.
// Decouples the window pipeline from output stall; uses ogi_pkg.
module ogi_out_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  ogi_pkg::out_word_t           word_i,
  input  logic                         stall_i,
  output logic                         valid_o,
  output ogi_pkg::out_word_t           word_o,
  output logic [ogi_pkg::FifoCntW-1:0] count_o
);
  import ogi_pkg::*;

  out_word_t         mem [4];
  logic [1:0]        wp_q, rp_q;
  logic [FifoCntW-1:0] cnt_q;
  logic              pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && !stall_i;
  assign word_o  = mem[rp_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wp_q] <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (pop)    rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + FifoCntW'(push_i) - FifoCntW'(pop);
    end
  end

endmodule

// ===== tb/occupancy_grid_inflation_chk.sv =====
// Occupancy grid inflation checker: tracks register writes and accepted words,
// predicts each inflated cell and compares it with the output channel. Uses ogi_pkg.
`timescale 1ns / 100ps

module occupancy_grid_inflation_chk (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ogi_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ogi_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  ogi_pkg::in_word_t            in_word_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  ogi_pkg::out_word_t           out_word_i,
  output int                           pending_o,
  output int                           fail_count_o
);
  import ogi_pkg::*;

  localparam int MaxW  = 512;
  localparam int MaxH  = 256;
  localparam int Depth = 2 * (7 * MaxW + 7) + 1;

  logic [7:0]        cells_q [Depth];
  int                in_pos, out_pos;
  bit                drain;
  logic [2:0]        radius;
  logic [9:0]        fwidth;
  logic [8:0]        fheight;
  logic signed [7:0] occ_val, infl_val;
  out_word_t         grid_expected_q[$];

  function automatic int width_eff();
    if (fwidth == 0) return 1;
    return (fwidth > MaxW) ? MaxW : int'(fwidth);
  endfunction

  function automatic int height_eff();
    if (fheight == 0) return 1;
    return (fheight > MaxH) ? MaxH : int'(fheight);
  endfunction

  function automatic logic signed [7:0] cell_at(int lin);
    return $signed(cells_q[lin % Depth]);
  endfunction

  // Inflate the cell at the output position, then advance it.
  function automatic out_word_t inflate_next();
    int w, h, r, n, row, col, lim, y, x;
    bit hit;
    logic signed [7:0] v;
    out_word_t res;
    w = width_eff();
    h = height_eff();
    r = int'(radius);
    n = w * h;
    row = out_pos / w;
    col = out_pos % w;
    lim = (r + 1) * (r + 1);
    v = cell_at(out_pos);
    hit = 0;
    for (int dy = -r; dy <= r; dy++) begin
      y = row + dy;
      if (y < 0 || y >= h) continue;
      for (int dx = -r; dx <= r; dx++) begin
        x = col + dx;
        if (x < 0 || x >= w || dy * dy + dx * dx >= lim) continue;
        if (cell_at(y * w + x) == occ_val) hit = 1;
      end
    end
    if (hit && infl_val > v) v = infl_val;
    res.out_value  = v;
    res.frame_last = (out_pos + 1 == n);
    out_pos++;
    if (out_pos >= n) begin
      in_pos = 0;
      out_pos = 0;
      drain = 0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    int n, lag, errs;
    out_word_t want;
    errs = 0;
    if (!rst_ni) begin
      radius   = 3'(RadiusReset);
      fwidth   = 10'(WidthReset);
      fheight  = 9'(HeightReset);
      occ_val  = OccupiedReset;
      infl_val = InflatedReset;
      in_pos = 0;
      out_pos = 0;
      drain = 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i && cfg_idx_i <= REG_INFLATED) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_RADIUS:   radius = cfg_data_i[2:0];
          REG_WIDTH:    fwidth = cfg_data_i;
          REG_HEIGHT:   fheight = cfg_data_i[8:0];
          REG_OCCUPIED: occ_val = cfg_data_i[7:0];
          REG_INFLATED: infl_val = cfg_data_i[7:0];
          default: ;
        endcase
        in_pos = 0;
        out_pos = 0;
        drain = 0;
      end
      if (in_valid_i && !in_stall_i) begin
        n = width_eff() * height_eff();
        lag = int'(radius) * width_eff() + int'(radius);
        if (!in_word_i.func && !drain) begin
          cells_q[in_pos % Depth] = in_word_i.cell_value;
          in_pos++;
          if (in_pos >= n) drain = 1;
          if (in_pos > lag) grid_expected_q.push_back(inflate_next());
        end else if (drain && out_pos < n) begin
          grid_expected_q.push_back(inflate_next());
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (grid_expected_q.size() == 0) begin
          $error("unexpected output word %h", out_word_i);
          errs++;
        end else begin
          want = grid_expected_q.pop_front();
          if (out_word_i.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d", want.out_value, out_word_i.out_value);
            errs++;
          end
          if (out_word_i.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0b, got %0b", want.frame_last,
                   out_word_i.frame_last);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
    pending_o <= grid_expected_q.size();
  end

endmodule

// ===== tb/occupancy_grid_inflation_tb.sv =====
// Occupancy grid inflation testbench top: clock, reset, register writes, pixel
// stream with bursts and a stalling receiver. Uses ogi_pkg, the block and the checker.
`timescale 1ns / 100ps

module occupancy_grid_inflation_tb;
  import ogi_pkg::*;

  localparam int IdleLimit = 20000;

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                cfg_we = 0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 0;
  logic                in_stall;
  in_word_t            in_word = '0;
  logic                out_valid;
  logic                out_stall = 0;
  out_word_t           out_word;
  int                  pending, fails;
  int                  burst_left = 0;
  int                  idle_cycles = 0;
  int                  items = 0;
  int                  stall_mode = 0, mode_left = 0;
  logic signed [7:0]   cur_occ, cur_infl;

  occupancy_grid_inflation DUT (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_word_o(out_word)
  );

  occupancy_grid_inflation_chk u_chk (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_word_i(in_word),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_word_i(out_word),
    .pending_o(pending), .fail_count_o(fails)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Receiver stall pattern: none, scattered, or long runs, switched now and then.
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      default: out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(bit func, logic [7:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1;
    in_word.func <= func;
    in_word.cell_value <= value;
    do @(posedge clk_i); while (in_stall);
    items++;
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 0;
  endtask

  // Hold the input until every result is out, then let the block settle.
  task automatic wait_quiet();
    in_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic setup(int r, int wdata, int hdata, logic [7:0] occ, logic [7:0] infl);
    wait_quiet();
    write_reg(REG_RADIUS, CfgDataW'(r));
    write_reg(REG_WIDTH, CfgDataW'(wdata));
    write_reg(REG_HEIGHT, CfgDataW'(hdata));
    write_reg(REG_OCCUPIED, {2'b00, occ});
    write_reg(REG_INFLATED, {2'b00, infl});
    cur_occ = occ;
    cur_infl = infl;
  endtask

  function automatic logic [7:0] grid_cell();
    case ($urandom_range(0, 9))
      0, 1:    return cur_occ;
      2:       return cur_infl;
      3:       return 8'h80;
      4:       return 8'h7f;
      default: return 8'($urandom);
    endcase
  endfunction

  // One frame: pixels, then drain words; noisy frames mix in ignored drain
  // words and pixels past the frame end.
  task automatic run_frame(int r, int wdata, int hdata, bit noisy);
    int w, h, n, lag, drains;
    w = (wdata == 0) ? 1 : (wdata > 512 ? 512 : wdata);
    h = (hdata == 0) ? 1 : (hdata > 256 ? 256 : hdata);
    n = w * h;
    lag = r * w + r;
    drains = (lag >= n) ? n : lag;
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) send_word(1, 8'($urandom));
      send_word(0, grid_cell());
    end
    for (int d = 0; d < drains; d++) begin
      if (noisy && $urandom_range(0, 2) == 0) send_word(0, 8'($urandom));
      else send_word(1, 8'($urandom));
    end
  endtask

  initial begin
    int r, wd, hd;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    setup(1, 3, 2, 8'h80, 8'h7f);
    run_frame(1, 3, 2, 1);
    setup(0, 2, 2, 8'h7f, 8'h80);
    run_frame(0, 2, 2, 1);
    wait_quiet();
    write_reg(reg_idx_e'(5), 10'h3ff);
    run_frame(0, 2, 2, 0);

    setup(0, 0, 511, 8'($urandom), 8'($urandom));
    run_frame(0, 0, 511, 1);
    setup(7, 1, 1, 8'($urandom), 8'($urandom));
    run_frame(7, 1, 1, 0);

    while (items < 550) begin
      r  = $urandom_range(0, 7);
      wd = $urandom_range(1, 24);
      hd = $urandom_range(1, 10);
      setup(r, wd, hd, grid_cell(), 8'($urandom));
      run_frame(r, wd, hd, $urandom_range(0, 3) == 0);
    end

    in_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
